@@ rtl/tcpq_pkg.sv @@
// Shared types and constants for the three-class priority queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tcpq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int NUM_CLASSES    = 3;

    localparam int CMD_W       = 2;
    localparam int CLS_W       = 2;
    localparam int PAYLOAD_W   = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;
    localparam int M_TUSER_W   = 1;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ACCEL = 2'd2;

    localparam logic [CLS_W-1:0] CLS_LOW    = 2'd0;
    localparam logic [CLS_W-1:0] CLS_NORMAL = 2'd1;
    localparam logic [CLS_W-1:0] CLS_HIGH   = 2'd2;

    // Strobes from the list controller to the slot memories.
    typedef struct packed {
        logic rd_en;
        logic pay_we;
        logic link_we;
    } mem_ctl_t;

    typedef struct packed {
        logic                   item_valid;
        logic [PAYLOAD_W-1:0]   payload_out;
        logic                   put_dropped;
        logic                   queue_empty;
        logic [COUNT_OUT_W-1:0] entry_count;
    } result_t;

endpackage

@@ rtl/tcpq_store.sv @@
// Slot memories: payload and next-slot link, one write and one registered read each.
// Depends on tcpq_pkg for the control strobe struct.
`timescale 1ns / 1ps

module tcpq_store
    import tcpq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  mem_ctl_t                     ctl,
    input  logic [$clog2(DEPTH)-1:0]     pay_rd_addr,
    input  logic [$clog2(DEPTH)-1:0]     link_rd_addr,
    input  logic [$clog2(DEPTH)-1:0]     pay_wr_addr,
    input  logic [DATA_WIDTH-1:0]        pay_wr_data,
    input  logic [$clog2(DEPTH)-1:0]     link_wr_addr,
    input  logic [$clog2(DEPTH)-1:0]     link_wr_data,
    output logic [DATA_WIDTH-1:0]        pay_rd_data,
    output logic [$clog2(DEPTH)-1:0]     link_rd_data
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [DATA_WIDTH-1:0] payload_mem [DEPTH];
    logic [IDX_W-1:0]      link_mem    [DEPTH];
    logic [DATA_WIDTH-1:0] rd_payload_reg;
    logic [IDX_W-1:0]      rd_link_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.pay_we)
        begin
            payload_mem[pay_wr_addr] <= pay_wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_payload_reg <= payload_mem[pay_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.link_we)
        begin
            link_mem[link_wr_addr] <= link_wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_link_reg <= link_mem[link_rd_addr];
        end
    end

    assign pay_rd_data  = rd_payload_reg;
    assign link_rd_data = rd_link_reg;

endmodule

@@ rtl/tcpq_ctrl.sv @@
// List controller: class heads, tails and counts, free-slot allocation and
// the read/update sequence. Depends on tcpq_pkg.
`timescale 1ns / 1ps

module tcpq_ctrl
    import tcpq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [CMD_W-1:0]             command,
    input  logic [CLS_W-1:0]             priority_class,
    input  logic [PAYLOAD_W-1:0]         payload_in,
    input  logic                         out_free,
    output logic                         res_valid,
    output result_t                      result,
    output mem_ctl_t                     mem_ctl,
    output logic [$clog2(DEPTH)-1:0]     pay_rd_addr,
    output logic [$clog2(DEPTH)-1:0]     link_rd_addr,
    output logic [$clog2(DEPTH)-1:0]     pay_wr_addr,
    output logic [DATA_WIDTH-1:0]        pay_wr_data,
    output logic [$clog2(DEPTH)-1:0]     link_wr_addr,
    output logic [$clog2(DEPTH)-1:0]     link_wr_data,
    input  logic [DATA_WIDTH-1:0]        pay_rd_data,
    input  logic [$clog2(DEPTH)-1:0]     link_rd_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                  state_reg, state_next;
    logic [IDX_W-1:0]      head_reg  [NUM_CLASSES];
    logic [IDX_W-1:0]      head_next [NUM_CLASSES];
    logic [IDX_W-1:0]      tail_reg  [NUM_CLASSES];
    logic [IDX_W-1:0]      tail_next [NUM_CLASSES];
    logic [CNT_W-1:0]      count_reg [NUM_CLASSES];
    logic [CNT_W-1:0]      count_next[NUM_CLASSES];
    logic [CNT_W-1:0]      fresh_reg, fresh_next;
    logic [IDX_W-1:0]      free_head_reg, free_head_next;
    logic [CMD_W-1:0]      cmd_reg;
    logic [CLS_W-1:0]      cls_reg;
    logic [DATA_WIDTH-1:0] data_reg;

    logic                  accept;
    logic                  go;
    logic [CNT_W-1:0]      total;
    logic [CNT_W-1:0]      total_after;
    logic                  full;
    logic                  use_fresh;
    logic [IDX_W-1:0]      new_slot;
    logic [CLS_W-1:0]      get_cls;
    logic [IDX_W-1:0]      get_slot;
    logic                  cls_ok;
    logic [CLS_W-1:0]      put_cls;
    logic                  put_ok;
    logic                  drop;
    logic                  get_ok;
    logic                  accel_ok;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign go       = (state_reg == ST_EXEC) && out_free;

    assign total     = count_reg[0] + count_reg[1] + count_reg[2];
    assign full      = (total == CNT_W'(DEPTH));
    assign use_fresh = (fresh_reg != CNT_W'(DEPTH));
    // Slots never used come from the fresh counter, recycled ones from the free list.
    assign new_slot  = use_fresh ? fresh_reg[IDX_W-1:0] : free_head_reg;

    always_comb
    begin
        if (count_reg[CLS_HIGH] != '0)
        begin
            get_cls = CLS_HIGH;
        end
        else if (count_reg[CLS_NORMAL] != '0)
        begin
            get_cls = CLS_NORMAL;
        end
        else
        begin
            get_cls = CLS_LOW;
        end
    end

    assign get_slot = head_reg[get_cls];

    assign cls_ok   = (cls_reg == CLS_LOW) || (cls_reg == CLS_NORMAL) || (cls_reg == CLS_HIGH);
    assign put_cls  = cls_ok ? cls_reg : CLS_LOW;
    assign put_ok   = (cmd_reg == CMD_PUT) && cls_ok && !full;
    assign drop     = (cmd_reg == CMD_PUT) && cls_ok && full;
    assign get_ok   = (cmd_reg == CMD_GET) && (total != '0);
    assign accel_ok = (cmd_reg == CMD_ACCEL) && (count_reg[CLS_LOW] != '0);

    // Issue reads on accept; state registers stay put until the update cycle.
    assign pay_rd_addr  = get_slot;
    assign link_rd_addr = (command == CMD_PUT) ? free_head_reg : get_slot;
    assign pay_wr_addr  = new_slot;
    assign pay_wr_data  = data_reg;

    always_comb
    begin
        mem_ctl.rd_en   = accept;
        mem_ctl.pay_we  = go && put_ok;
        mem_ctl.link_we = 1'b0;
        link_wr_addr    = get_slot;
        link_wr_data    = free_head_reg;
        if (put_ok && (count_reg[put_cls] != '0))
        begin
            mem_ctl.link_we = go;
            link_wr_addr    = tail_reg[put_cls];
            link_wr_data    = new_slot;
        end
        else if (get_ok)
        begin
            // push the freed slot onto the free list
            mem_ctl.link_we = go;
            link_wr_addr    = get_slot;
            link_wr_data    = free_head_reg;
        end
        else if (accel_ok && (count_reg[CLS_HIGH] != '0))
        begin
            mem_ctl.link_we = go;
            link_wr_addr    = tail_reg[CLS_HIGH];
            link_wr_data    = head_reg[CLS_LOW];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        fresh_next     = fresh_reg;
        free_head_next = free_head_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (go)
                begin
                    state_next = ST_IDLE;
                    if (put_ok)
                    begin
                        if (count_reg[put_cls] == '0)
                        begin
                            head_next[put_cls] = new_slot;
                        end
                        tail_next[put_cls]  = new_slot;
                        count_next[put_cls] = count_reg[put_cls] + CNT_W'(1);
                        if (use_fresh)
                        begin
                            fresh_next = fresh_reg + CNT_W'(1);
                        end
                        else
                        begin
                            free_head_next = link_rd_data;
                        end
                    end
                    if (get_ok)
                    begin
                        count_next[get_cls] = count_reg[get_cls] - CNT_W'(1);
                        if (count_reg[get_cls] != CNT_W'(1))
                        begin
                            head_next[get_cls] = link_rd_data;
                        end
                        free_head_next = get_slot;
                    end
                    if (accel_ok)
                    begin
                        if (count_reg[CLS_HIGH] == '0)
                        begin
                            head_next[CLS_HIGH] = head_reg[CLS_LOW];
                        end
                        tail_next[CLS_HIGH]  = tail_reg[CLS_LOW];
                        count_next[CLS_HIGH] = count_reg[CLS_HIGH] + count_reg[CLS_LOW];
                        count_next[CLS_LOW]  = '0;
                        head_next[CLS_LOW]   = '0;
                        tail_next[CLS_LOW]   = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign total_after = total + CNT_W'(put_ok) - CNT_W'(get_ok);

    assign res_valid          = go;
    assign result.item_valid  = get_ok;
    assign result.payload_out = get_ok ? PAYLOAD_W'(pay_rd_data) : '0;
    assign result.put_dropped = drop;
    assign result.queue_empty = (total_after == '0);
    assign result.entry_count = COUNT_OUT_W'(total_after);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '{default: '0};
            tail_reg      <= '{default: '0};
            count_reg     <= '{default: '0};
            fresh_reg     <= '0;
            free_head_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            free_head_reg <= free_head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            cls_reg  <= priority_class;
            data_reg <= DATA_WIDTH'(payload_in);
        end
    end

endmodule

@@ rtl/three_class_priority_queue_core.sv @@
// Each beat has a read phase on the slot memories (head payload and link, or the
// next free-list link) and an update phase that changes the lists and writes back;
// the core accepts no new beat until the update phase of the last one has run.
// A result waits in an output register, and the next beat is accepted meanwhile;
// it then holds in its update cycle until that register drains. Free slots are
// handed out by a fill counter first and then by a free list, so no clearing
// pass follows reset. Top level of the three-class priority queue; depends on
// tcpq_pkg, tcpq_ctrl and tcpq_store.
`timescale 1ns / 1ps

module three_class_priority_queue_core
    import tcpq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // priority_class[1:0], payload_in[33:2], zero pad
    input  logic [CMD_W-1:0]     s_tuser,   // command[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // payload_out[31:0], put_dropped[32],
                                            // queue_empty[33], entry_count[38:34], zero pad
    output logic [M_TUSER_W-1:0] m_tuser    // item_valid[0]
);

    localparam int IDX_W = $clog2(DEPTH);

    mem_ctl_t              mem_ctl;
    logic [IDX_W-1:0]      pay_rd_addr;
    logic [IDX_W-1:0]      link_rd_addr;
    logic [IDX_W-1:0]      pay_wr_addr;
    logic [DATA_WIDTH-1:0] pay_wr_data;
    logic [IDX_W-1:0]      link_wr_addr;
    logic [IDX_W-1:0]      link_wr_data;
    logic [DATA_WIDTH-1:0] pay_rd_data;
    logic [IDX_W-1:0]      link_rd_data;
    logic                  out_free;
    logic                  res_valid;
    result_t               result;
    logic                  m_valid_reg;
    result_t               result_reg;

    assign out_free = !m_valid_reg || m_tready;

    tcpq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .command        (s_tuser),
        .priority_class (s_tdata[CLS_W-1:0]),
        .payload_in     (s_tdata[CLS_W+PAYLOAD_W-1:CLS_W]),
        .out_free       (out_free),
        .res_valid      (res_valid),
        .result         (result),
        .mem_ctl        (mem_ctl),
        .pay_rd_addr    (pay_rd_addr),
        .link_rd_addr   (link_rd_addr),
        .pay_wr_addr    (pay_wr_addr),
        .pay_wr_data    (pay_wr_data),
        .link_wr_addr   (link_wr_addr),
        .link_wr_data   (link_wr_data),
        .pay_rd_data    (pay_rd_data),
        .link_rd_data   (link_rd_data)
    );

    tcpq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk          (clk),
        .ctl          (mem_ctl),
        .pay_rd_addr  (pay_rd_addr),
        .link_rd_addr (link_rd_addr),
        .pay_wr_addr  (pay_wr_addr),
        .pay_wr_data  (pay_wr_data),
        .link_wr_addr (link_wr_addr),
        .link_wr_data (link_wr_data),
        .pay_rd_data  (pay_rd_data),
        .link_rd_data (link_rd_data)
    );

    // Output register: load a finished result, drop the flag once the beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, result_reg.entry_count, result_reg.queue_empty,
                       result_reg.put_dropped, result_reg.payload_out};
    assign m_tuser  = result_reg.item_valid;

endmodule
